// ===== hdl/mts_pkg.sv =====
// ---------------------------------------------------------------------------
// mts_pkg
// Shared types, register indexes and widths of the move-to-target step block.
// ---------------------------------------------------------------------------
package mts_pkg;

	localparam int DataW     = 32;
	localparam int TimeW     = 16;
	localparam int CfgIdxW   = 2;
	localparam int SqrtSteps = 33;
	localparam int DivSteps  = 32;

	typedef enum logic [1:0] {
		MODE_INSTANT   = 2'd0,
		MODE_CONST     = 2'd1,
		MODE_ACC_LOCK  = 2'd2,
		MODE_ACC_FREE  = 2'd3
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MODE   = 2'd0,
		REG_TX     = 2'd1,
		REG_TY     = 2'd2,
		REG_SPEED  = 2'd3
	} reg_idx_t;

	// per-item context that travels the whole pipe
	typedef struct packed {
		logic signed [DataW-1:0] px;
		logic signed [DataW-1:0] py;
		logic                    sx;
		logic                    sy;
		logic [DataW-1:0]        ax;
		logic [DataW-1:0]        ay;
		mode_t                   mode;
	} carry_t;

	function automatic logic [DataW-1:0] sat34(input logic signed [DataW+1:0] v);
		logic [DataW-1:0] r;
		if (v > $signed({3'b000, {(DataW-1){1'b1}}}))
			r = {1'b0, {(DataW-1){1'b1}}};
		else if (v < $signed({3'b111, {(DataW-1){1'b0}}}))
			r = {1'b1, {(DataW-1){1'b0}}};
		else
			r = v[DataW-1:0];
		return r;
	endfunction

endpackage

// ===== hdl/mts_req_if.sv =====
// ---------------------------------------------------------------------------
// mts_req_if
// Input item channel: time step and current position.
// ---------------------------------------------------------------------------
interface mts_req_if;
	logic               valid;
	logic               ready;
	logic [15:0]        time_step;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;

	modport source (output valid, time_step, pos_x, pos_y, input ready);
	modport sink   (input valid, time_step, pos_x, pos_y, output ready);
endinterface

// ===== hdl/mts_rsp_if.sv =====
// ---------------------------------------------------------------------------
// mts_rsp_if
// Result channel: new position, velocity increment and done flag.
// ---------------------------------------------------------------------------
interface mts_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] new_pos_x;
	logic signed [31:0] new_pos_y;
	logic signed [31:0] vel_dx;
	logic signed [31:0] vel_dy;
	logic               done_res;

	modport source (output valid, new_pos_x, new_pos_y, vel_dx, vel_dy, done_res,
		input ready);
	modport sink   (input valid, new_pos_x, new_pos_y, vel_dx, vel_dy, done_res,
		output ready);
endinterface

// ===== hdl/mts_cfg_if.sv =====
// ---------------------------------------------------------------------------
// mts_cfg_if
// Register write channel: register index and write data.
// ---------------------------------------------------------------------------
interface mts_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/move_to_target_step.sv =====
// One step of moving a 2-D point toward the configured target at the configured
// speed. The block takes one item per clock while the output is not stalled and
// presents its result through 70 register stages: three for the difference,
// squares and their sum, 33 for the bit-pair square root (one root bit per
// stage), one for the snap test and the distance-times-step products, 32 for
// the two restoring dividers (one quotient bit per stage) and one for the
// output register. The whole pipe advances together; while a result waits at the
// output the pipe holds and req.ready is low. Registers may be written only while
// the pipe is empty.
// ---------------------------------------------------------------------------
// move_to_target_step
// Fully pipelined move-to-target position update with snap and saturation.
// ---------------------------------------------------------------------------
module move_to_target_step
	import mts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	mts_req_if.sink   req,
	mts_rsp_if.source rsp,
	mts_cfg_if.sink   cfg
);

	// configuration
	mode_t                   mode_q;
	logic signed [DataW-1:0] tx_q;
	logic signed [DataW-1:0] ty_q;
	logic [DataW-1:0]        speed_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_INSTANT;
			tx_q    <= '0;
			ty_q    <= '0;
			speed_q <= '0;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_MODE:  mode_q  <= mode_t'(cfg.data[1:0]);
				REG_TX:    tx_q    <= cfg.data;
				REG_TY:    ty_q    <= cfg.data;
				REG_SPEED: speed_q <= cfg.data;
				default:   ;
			endcase
		end
	end

	// global advance
	logic out_v_q;
	logic en;
	assign en        = !out_v_q || rsp.ready;
	assign req.ready = en;

	// stage 1: differences, magnitudes, speed times dt
	logic                      v_s1;
	carry_t                    c_s1;
	logic [DataW+TimeW-1:0]    p_s1;
	logic signed [DataW:0]     dx;
	logic signed [DataW:0]     dy;
	logic [DataW:0]            dxm;
	logic [DataW:0]            dym;

	assign dx  = {tx_q[DataW-1], tx_q} - {req.pos_x[DataW-1], req.pos_x};
	assign dy  = {ty_q[DataW-1], ty_q} - {req.pos_y[DataW-1], req.pos_y};
	assign dxm = dx[DataW] ? -dx : dx;
	assign dym = dy[DataW] ? -dy : dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= req.valid && req.ready;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1.px   <= req.pos_x;
			c_s1.py   <= req.pos_y;
			c_s1.sx   <= dx[DataW];
			c_s1.sy   <= dy[DataW];
			c_s1.ax   <= dxm[DataW-1:0];
			c_s1.ay   <= dym[DataW-1:0];
			c_s1.mode <= mode_q;
			p_s1      <= speed_q * req.time_step;
		end
	end

	// stage 2: squares
	logic                   v_s2;
	carry_t                 c_s2;
	logic [DataW+TimeW-1:0] p_s2;
	logic [2*DataW-1:0]     sqx_s2;
	logic [2*DataW-1:0]     sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2   <= c_s1;
			p_s2   <= p_s1;
			sqx_s2 <= c_s1.ax * c_s1.ax;
			sqy_s2 <= c_s1.ay * c_s1.ay;
		end
	end

	// stage 3: sum of squares, radicand padded to an even bit count
	logic                   v_s3;
	carry_t                 c_s3;
	logic [DataW+TimeW-1:0] p_s3;
	logic [2*SqrtSteps-1:0] rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3   <= c_s2;
			p_s3   <= p_s2;
			rad_s3 <= {1'b0, {1'b0, sqx_s2} + {1'b0, sqy_s2}};
		end
	end

	// square root, one root bit per stage
	logic                   sq_v    [SqrtSteps];
	carry_t                 sq_c    [SqrtSteps];
	logic [DataW+TimeW-1:0] sq_p    [SqrtSteps];
	logic [2*SqrtSteps-1:0] sq_rad  [SqrtSteps];
	logic [SqrtSteps-1:0]   sq_root [SqrtSteps];
	logic [SqrtSteps:0]     sq_rem  [SqrtSteps];

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
		logic                   v_in;
		carry_t                 c_in;
		logic [DataW+TimeW-1:0] p_in;
		logic [2*SqrtSteps-1:0] rad_in;
		logic [SqrtSteps-1:0]   root_in;
		logic [SqrtSteps:0]     rem_in;
		logic [SqrtSteps+2:0]   rem_sh;
		logic [SqrtSteps+2:0]   trial;
		logic [SqrtSteps+2:0]   rem_sub;
		logic                   ge;

		if (k == 0) begin : g_first
			assign v_in    = v_s3;
			assign c_in    = c_s3;
			assign p_in    = p_s3;
			assign rad_in  = rad_s3;
			assign root_in = '0;
			assign rem_in  = '0;
		end else begin : g_next
			assign v_in    = sq_v[k-1];
			assign c_in    = sq_c[k-1];
			assign p_in    = sq_p[k-1];
			assign rad_in  = sq_rad[k-1];
			assign root_in = sq_root[k-1];
			assign rem_in  = sq_rem[k-1];
		end

		assign rem_sh  = {rem_in, rad_in[2*(SqrtSteps-1-k)+1 -: 2]};
		assign trial   = {1'b0, root_in, 2'b01};
		assign ge      = rem_sh >= trial;
		assign rem_sub = rem_sh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v[k] <= 1'b0;
			else if (en) sq_v[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_c[k]    <= c_in;
				sq_p[k]    <= p_in;
				sq_rad[k]  <= rad_in;
				sq_root[k] <= {root_in[SqrtSteps-2:0], ge};
				// remainder never exceeds twice the root, so it fits one bit over the root
				sq_rem[k]  <= ge ? rem_sub[SqrtSteps:0] : rem_sh[SqrtSteps:0];
			end
		end
	end

	// snap test and distance-times-step products
	logic                 v_m;
	carry_t               c_m;
	logic [SqrtSteps-1:0] len_m;
	logic                 snap_m;
	logic                 lz_m;
	logic [2*DataW-1:0]   nx_m;
	logic [2*DataW-1:0]   ny_m;
	logic [SqrtSteps-1:0] len_w;
	logic [DataW-1:0]     step_w;

	assign len_w  = sq_root[SqrtSteps-1];
	assign step_w = sq_p[SqrtSteps-1][DataW+TimeW-1:TimeW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m <= 1'b0;
		else if (en) v_m <= sq_v[SqrtSteps-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_m    <= sq_c[SqrtSteps-1];
			len_m  <= len_w;
			snap_m <= {len_w, {TimeW{1'b0}}} < {1'b0, sq_p[SqrtSteps-1]};
			lz_m   <= len_w == '0;
			nx_m   <= sq_c[SqrtSteps-1].ax * step_w;
			ny_m   <= sq_c[SqrtSteps-1].ay * step_w;
		end
	end

	// restoring dividers, one quotient bit per stage; the quotient is known to
	// fit below the distance magnitude, so the upper dividend half seeds the
	// remainder
	logic                 dv_v    [DivSteps];
	carry_t               dv_c    [DivSteps];
	logic                 dv_snap [DivSteps];
	logic                 dv_lz   [DivSteps];
	logic [SqrtSteps-1:0] dv_len  [DivSteps];
	logic [DataW-1:0]     dv_lox  [DivSteps];
	logic [DataW-1:0]     dv_loy  [DivSteps];
	logic [SqrtSteps-1:0] dv_rx   [DivSteps];
	logic [SqrtSteps-1:0] dv_ry   [DivSteps];
	logic [DataW-1:0]     dv_qx   [DivSteps];
	logic [DataW-1:0]     dv_qy   [DivSteps];

	for (genvar j = 0; j < DivSteps; j++) begin : g_div
		logic                 v_in;
		carry_t               c_in;
		logic                 snap_in;
		logic                 lz_in;
		logic [SqrtSteps-1:0] len_in;
		logic [DataW-1:0]     lox_in;
		logic [DataW-1:0]     loy_in;
		logic [SqrtSteps-1:0] rx_in;
		logic [SqrtSteps-1:0] ry_in;
		logic [DataW-1:0]     qx_in;
		logic [DataW-1:0]     qy_in;
		logic [SqrtSteps:0]   rx_sh;
		logic [SqrtSteps:0]   ry_sh;
		logic                 gex;
		logic                 gey;
		logic [SqrtSteps:0]   rx_sub;
		logic [SqrtSteps:0]   ry_sub;

		if (j == 0) begin : g_first
			assign v_in    = v_m;
			assign c_in    = c_m;
			assign snap_in = snap_m;
			assign lz_in   = lz_m;
			assign len_in  = len_m;
			assign lox_in  = nx_m[DataW-1:0];
			assign loy_in  = ny_m[DataW-1:0];
			assign rx_in   = {1'b0, nx_m[2*DataW-1:DataW]};
			assign ry_in   = {1'b0, ny_m[2*DataW-1:DataW]};
			assign qx_in   = '0;
			assign qy_in   = '0;
		end else begin : g_next
			assign v_in    = dv_v[j-1];
			assign c_in    = dv_c[j-1];
			assign snap_in = dv_snap[j-1];
			assign lz_in   = dv_lz[j-1];
			assign len_in  = dv_len[j-1];
			assign lox_in  = dv_lox[j-1];
			assign loy_in  = dv_loy[j-1];
			assign rx_in   = dv_rx[j-1];
			assign ry_in   = dv_ry[j-1];
			assign qx_in   = dv_qx[j-1];
			assign qy_in   = dv_qy[j-1];
		end

		assign rx_sh  = {rx_in, lox_in[DivSteps-1-j]};
		assign ry_sh  = {ry_in, loy_in[DivSteps-1-j]};
		assign gex    = rx_sh >= {1'b0, len_in};
		assign gey    = ry_sh >= {1'b0, len_in};
		assign rx_sub = rx_sh - {1'b0, len_in};
		assign ry_sub = ry_sh - {1'b0, len_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[j] <= 1'b0;
			else if (en) dv_v[j] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_c[j]    <= c_in;
				dv_snap[j] <= snap_in;
				dv_lz[j]   <= lz_in;
				dv_len[j]  <= len_in;
				dv_lox[j]  <= lox_in;
				dv_loy[j]  <= loy_in;
				dv_rx[j]   <= gex ? rx_sub[SqrtSteps-1:0] : rx_sh[SqrtSteps-1:0];
				dv_ry[j]   <= gey ? ry_sub[SqrtSteps-1:0] : ry_sh[SqrtSteps-1:0];
				dv_qx[j]   <= {qx_in[DataW-2:0], gex};
				dv_qy[j]   <= {qy_in[DataW-2:0], gey};
			end
		end
	end

	// output stage
	carry_t                  cf;
	logic                    done_w;
	logic [DataW-1:0]        mx_mag;
	logic [DataW-1:0]        my_mag;
	logic signed [DataW+1:0] mx;
	logic signed [DataW+1:0] my;
	logic signed [DataW+1:0] sum_x;
	logic signed [DataW+1:0] sum_y;
	logic signed [DataW-1:0] npx_w;
	logic signed [DataW-1:0] npy_w;
	logic signed [DataW-1:0] vdx_w;
	logic signed [DataW-1:0] vdy_w;

	assign cf     = dv_c[DivSteps-1];
	assign done_w = (cf.mode == MODE_INSTANT) || dv_snap[DivSteps-1];
	// zero distance with zero step moves nothing
	assign mx_mag = dv_lz[DivSteps-1] ? '0 : dv_qx[DivSteps-1];
	assign my_mag = dv_lz[DivSteps-1] ? '0 : dv_qy[DivSteps-1];
	assign mx     = cf.sx ? -$signed({2'b00, mx_mag}) : $signed({2'b00, mx_mag});
	assign my     = cf.sy ? -$signed({2'b00, my_mag}) : $signed({2'b00, my_mag});
	assign sum_x  = {{2{cf.px[DataW-1]}}, cf.px} + mx;
	assign sum_y  = {{2{cf.py[DataW-1]}}, cf.py} + my;

	always_comb begin
		npx_w = cf.px;
		npy_w = cf.py;
		vdx_w = '0;
		vdy_w = '0;
		if (done_w) begin
			npx_w = tx_q;
			npy_w = ty_q;
		end else begin
			case (cf.mode)
				MODE_CONST: begin
					npx_w = sat34(sum_x);
					npy_w = sat34(sum_y);
				end
				MODE_ACC_LOCK, MODE_ACC_FREE: begin
					vdx_w = sat34(mx);
					vdy_w = sat34(my);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= dv_v[DivSteps-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.new_pos_x <= npx_w;
			rsp.new_pos_y <= npy_w;
			rsp.vel_dx    <= vdx_w;
			rsp.vel_dy    <= vdy_w;
			rsp.done_res  <= done_w;
		end
	end

	assign rsp.valid = out_v_q;

	// checks
	a_done_no_vel: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.done_res |-> rsp.vel_dx == '0 && rsp.vel_dy == '0)
		else $error("velocity increment reported with done");

	a_hold_stage1: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(out_v_q))
		else $error("pipe moved while the output was stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && !dv_v[DivSteps-1] |=> !rsp.valid)
		else $error("result repeated after its transaction");

	a_no_accept_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !rsp.ready |-> !req.ready)
		else $error("input taken while the pipe was held");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Streams position updates through move_to_target_step under several register
// settings and random handshake gaps, and checks every result against an
// internal fixed-point predictor of the instant, snap, constant and acceleration modes.
// ---------------------------------------------------------------------------
module tb_top
	import mts_pkg::*;
();

	typedef struct packed {
		logic [15:0]        time_step;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} step_item_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] vel_dx;
		logic signed [31:0] vel_dy;
		logic               done_res;
	} step_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mts_req_if req ();
	mts_rsp_if rsp ();
	mts_cfg_if cfg ();

	move_to_target_step dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	always #2 clk = ~clk;

	// predictor copy of the registers
	mode_t              cur_mode  = MODE_INSTANT;
	logic signed [31:0] cur_tx    = '0;
	logic signed [31:0] cur_ty    = '0;
	logic [31:0]        cur_speed = '0;

	step_item_t pending_steps[$];
	step_res_t  expected_moves[$];
	int         fail_count = 0;

	function automatic logic [31:0] sat_to32(input logic signed [65:0] v);
		if (v > 66'sh7fffffff)
			return 32'h7fffffff;
		if (v < -66'sh80000000)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic logic [32:0] root_of(input logic [65:0] s);
		logic [32:0] root;
		logic [67:0] rem;
		logic [67:0] trial;
		root = '0;
		rem = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | s[2*i +: 2];
			trial = ({35'd0, root} << 2) | 68'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 33'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic step_res_t predict_move(input step_item_t it);
		step_res_t r;
		logic signed [65:0] dx, dy, mx, my;
		logic [65:0] ax, ay, sq, len, p, stp, m;
		r = '0;
		if (cur_mode == MODE_INSTANT) begin
			r.new_pos_x = cur_tx;
			r.new_pos_y = cur_ty;
			r.done_res = 1'b1;
			return r;
		end
		dx = 66'(cur_tx) - 66'(it.pos_x);
		dy = 66'(cur_ty) - 66'(it.pos_y);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		sq = ax * ax + ay * ay;
		len = 66'(root_of(sq));
		p = 66'(cur_speed) * 66'(it.time_step);
		if ((len << 16) < p) begin
			r.new_pos_x = cur_tx;
			r.new_pos_y = cur_ty;
			r.done_res = 1'b1;
			return r;
		end
		stp = p >> 16;
		mx = 0;
		my = 0;
		if (len != 0) begin
			m = (ax * stp) / len;
			mx = dx < 0 ? -$signed(m) : $signed(m);
			m = (ay * stp) / len;
			my = dy < 0 ? -$signed(m) : $signed(m);
		end
		if (cur_mode == MODE_CONST) begin
			r.new_pos_x = sat_to32(66'(it.pos_x) + mx);
			r.new_pos_y = sat_to32(66'(it.pos_y) + my);
		end else begin
			r.new_pos_x = it.pos_x;
			r.new_pos_y = it.pos_y;
			r.vel_dx = sat_to32(mx);
			r.vel_dy = sat_to32(my);
		end
		return r;
	endfunction

	// driver: transactions are seen at the rising edge, inputs move at the falling edge
	int req_gap = 0;
	bit req_acc = 1'b0;
	bit hold_send = 1'b0;

	always @(posedge clk) begin
		req_acc <= arst_n && req.valid && req.ready;
		if (arst_n && req.valid && req.ready) begin
			step_item_t it;
			it = pending_steps.pop_front();
			expected_moves = {expected_moves, predict_move(it)};
		end
	end

	always @(negedge clk) begin
		int gap;
		gap = 0;
		if (arst_n) begin
			if (req_acc) begin
				gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 8);
				if (gap == 0 && pending_steps.size() > 0 && !hold_send) begin
					req.time_step <= pending_steps[0].time_step;
					req.pos_x <= pending_steps[0].pos_x;
					req.pos_y <= pending_steps[0].pos_y;
					req.valid <= 1'b1;
				end else begin
					req_gap <= (gap > 0) ? gap - 1 : 0;
					req.valid <= 1'b0;
				end
			end else if (!req.valid && pending_steps.size() > 0 && !hold_send) begin
				if (req_gap > 0) begin
					req_gap <= req_gap - 1;
				end else begin
					req.time_step <= pending_steps[0].time_step;
					req.pos_x <= pending_steps[0].pos_x;
					req.pos_y <= pending_steps[0].pos_y;
					req.valid <= 1'b1;
				end
			end
		end
	end

	// monitor
	bit rsp_acc = 1'b0;
	always @(posedge clk) begin
		rsp_acc <= rsp.valid && rsp.ready;
		if (rsp.valid && rsp.ready) begin
			step_res_t got, exp_r;
			got = {rsp.new_pos_x, rsp.new_pos_y, rsp.vel_dx, rsp.vel_dy, rsp.done_res};
			if (expected_moves.size() == 0) begin
				$error("result transaction with nothing expected");
				fail_count++;
			end else begin
				exp_r = expected_moves.pop_front();
				if (got.new_pos_x !== exp_r.new_pos_x) begin
					$error("new_pos_x exp %0d got %0d", exp_r.new_pos_x, got.new_pos_x);
					fail_count++;
				end
				if (got.new_pos_y !== exp_r.new_pos_y) begin
					$error("new_pos_y exp %0d got %0d", exp_r.new_pos_y, got.new_pos_y);
					fail_count++;
				end
				if (got.vel_dx !== exp_r.vel_dx) begin
					$error("vel_dx exp %0d got %0d", exp_r.vel_dx, got.vel_dx);
					fail_count++;
				end
				if (got.vel_dy !== exp_r.vel_dy) begin
					$error("vel_dy exp %0d got %0d", exp_r.vel_dy, got.vel_dy);
					fail_count++;
				end
				if (got.done_res !== exp_r.done_res) begin
					$error("done_res exp %0b got %0b", exp_r.done_res, got.done_res);
					fail_count++;
				end
			end
		end
	end

	// receiver stalls
	int rsp_gap = 0;
	always @(negedge clk) begin
		int gap;
		gap = 0;
		if (rsp_acc) begin
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 8);
			rsp_gap <= (gap > 0) ? gap - 1 : 0;
			rsp.ready <= (gap == 0);
		end else if (rsp_gap > 0) begin
			rsp_gap <= rsp_gap - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg.index <= idx;
		cfg.data <= val;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			REG_MODE:  cur_mode = mode_t'(val[1:0]);
			REG_TX:    cur_tx = val;
			REG_TY:    cur_ty = val;
			REG_SPEED: cur_speed = val;
			default:   ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain_pipe();
		while (pending_steps.size() > 0 || req.valid || expected_moves.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic queue_step(input logic [15:0] t, input logic [31:0] x,
		input logic [31:0] y);
		step_item_t it;
		it.time_step = t;
		it.pos_x = x;
		it.pos_y = y;
		pending_steps = {pending_steps, it};
	endtask

	function automatic logic [31:0] rand_pos(input logic signed [31:0] c);
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return c + $signed(32'($urandom_range(0, 2000)) - 32'd1000);
			2: return c + $signed(($urandom() >> 8) - 32'h0080_0000);
			default: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 50)
				: 32'h80000000 + $urandom_range(0, 50);
		endcase
	endfunction

	initial begin
		req.valid = 1'b0;
		req.time_step = '0;
		req.pos_x = '0;
		req.pos_y = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_MODE;
		cfg.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset registers: instant mode
		queue_step(16'hffff, 32'h7fffffff, 32'h80000000);
		queue_step(16'h0000, 32'h0, 32'h0);
		drain_pipe();

		// directed: constant and acceleration modes, extremes and zero distance
		write_reg(REG_MODE, MODE_CONST);
		write_reg(REG_TX, 32'h7fffffff);
		write_reg(REG_TY, 32'h80000000);
		write_reg(REG_SPEED, 32'hffffffff);
		queue_step(16'hffff, 32'h80000000, 32'h7fffffff);
		queue_step(16'h0001, 32'h80000000, 32'h7fffffff);
		queue_step(16'h0000, 32'h7fffffff, 32'h80000000);
		queue_step(16'hffff, 32'h7fffffff, 32'h80000000);
		queue_step(16'h8000, 32'h0, 32'h0);
		drain_pipe();
		write_reg(REG_SPEED, 32'h0);
		queue_step(16'hffff, 32'h7fffffff, 32'h80000000);
		queue_step(16'hffff, 32'h80000000, 32'h7fffffff);
		queue_step(16'h1234, 32'h0, 32'h0);
		drain_pipe();
		write_reg(REG_SPEED, 32'h0001_0000);
		write_reg(REG_TX, 32'h0);
		write_reg(REG_TY, 32'h0);
		queue_step(16'hffff, 32'h0003_0000, 32'h0004_0000);
		queue_step(16'hffff, 32'h0000_0100, 32'h0);
		drain_pipe();
		for (int mm = MODE_ACC_LOCK; mm <= MODE_ACC_FREE; mm++) begin
			write_reg(REG_MODE, 32'(mm));
			write_reg(REG_TX, 32'h80000000);
			write_reg(REG_TY, 32'h7fffffff);
			write_reg(REG_SPEED, 32'h7fff_0000);
			queue_step(16'hffff, 32'h7fffffff, 32'h80000000);
			queue_step(16'h0100, 32'h0, 32'h0);
			queue_step(16'h0000, 32'h80000000, 32'h7fffffff);
			drain_pipe();
		end

		// random phases with new settings each time
		for (int ph = 0; ph < 13; ph++) begin
			write_reg(REG_MODE, $urandom_range(0, 3));
			write_reg(REG_TX, $urandom());
			write_reg(REG_TY, $urandom());
			case ($urandom_range(0, 3))
				0: write_reg(REG_SPEED, $urandom());
				1: write_reg(REG_SPEED, $urandom_range(0, 32'h0100_0000));
				2: write_reg(REG_SPEED, 32'hffffffff);
				default: write_reg(REG_SPEED, $urandom_range(0, 32'h0010_0000));
			endcase
			for (int k = 0; k < 50; k++)
				queue_step($urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 255)),
					rand_pos(cur_tx), rand_pos(cur_ty));
			// sender holds until the pipe has fully emptied in the middle of a phase
			if (ph == 5) begin
				while (pending_steps.size() > 25) @(posedge clk);
				hold_send = 1'b1;
				while (expected_moves.size() > 0 || req.valid) @(posedge clk);
				hold_send = 1'b0;
			end
			drain_pipe();
		end

		if (fail_count == 0 && expected_moves.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#8ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== move_to_target_step.f =====
hdl/mts_pkg.sv
hdl/mts_req_if.sv
hdl/mts_rsp_if.sv
hdl/mts_cfg_if.sv
hdl/move_to_target_step.sv
sim/tb_top.sv
